// ===== rtl/gyro_wheel_odometry_unit_defines.svh =====
// Assertion macros for the gyro wheel odometry unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef GYRO_WHEEL_ODOMETRY_UNIT_DEFINES_SVH
`define GYRO_WHEEL_ODOMETRY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define GWO_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define GWO_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GWO_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GWO_ASSERT(lbl, clk, rst, cond)
`define GWO_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define GWO_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/gwo_pkg.sv =====
// Shared types, constants and helper functions of the gyro wheel odometry unit.
// Used by gwo_cordic and gyro_wheel_odometry_unit; depends on nothing.
package gwo_pkg;

  localparam int GWO_WHEELS_PER_AXIS = 2;
  localparam int GWO_CORDIC_STEPS    = 16;
  localparam int GWO_S_TDATA_W       = 232;
  localparam int GWO_M_TDATA_W       = 80;
  localparam int GWO_ATAN_IDX_W      = 5;

  localparam logic [15:0] GWO_FULL_TURN    = 16'd36000;
  localparam logic [15:0] GWO_QUARTER_TURN = 16'd9000;
  localparam logic [27:0] GWO_CDEG_RAD_Q40 = 28'd191900981;
  localparam logic signed [33:0] GWO_ONE_Q30  = 34'sd1073741824;
  localparam logic signed [33:0] GWO_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [15:0] GWO_LOW_TURN = 16'sd30;

  localparam logic [29:0] GWO_ATAN [32] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097141,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
    30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0};

  typedef enum logic [2:0] {
    CFG_X_TRAVEL,
    CFG_Y_TRAVEL,
    CFG_X_OFFSET_FIRST,
    CFG_X_OFFSET_SECOND,
    CFG_Y_OFFSET_FIRST,
    CFG_Y_OFFSET_SECOND,
    CFG_WHEELS_IN_USE,
    CFG_TRACKING_ENABLED
  } gwo_cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_SAMPLE,
    REQ_LOAD_HEADING,
    REQ_LOAD_POSITION
  } gwo_req_t;

  typedef struct packed {
    logic signed [33:0] sin_q;
    logic signed [33:0] cos_q;
  } gwo_trig_t;

  function automatic logic signed [31:0] gwo_sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -68'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== rtl/gwo_cordic.sv =====
// Iterative rotation-mode CORDIC giving Q4.30 sine and cosine of a centidegree angle.
// Depends on gwo_pkg for the arctangent table, gain and angle constants.
module gwo_cordic
  import gwo_pkg::*;
#(
  parameter int CORDIC_STEPS = GWO_CORDIC_STEPS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] angle,
  output logic        done,
  output gwo_trig_t   trig
);

  localparam int IW = $clog2(CORDIC_STEPS);

  typedef enum logic [1:0] {C_IDLE, C_ZMUL, C_ITER, C_FIX} cstate_t;

  cstate_t            state;
  logic [1:0]         quad;
  logic [1:0]         quad_c;
  logic [15:0]        rem_c;
  logic [13:0]        rem;
  logic [IW-1:0]      step;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic [41:0]        zsum;

  always_comb begin
    if (angle >= 16'd27000) begin
      quad_c = 2'd3;
      rem_c  = angle - 16'd27000;
    end else if (angle >= 16'd18000) begin
      quad_c = 2'd2;
      rem_c  = angle - 16'd18000;
    end else if (angle >= GWO_QUARTER_TURN) begin
      quad_c = 2'd1;
      rem_c  = angle - GWO_QUARTER_TURN;
    end else begin
      quad_c = 2'd0;
      rem_c  = angle;
    end
  end

  assign zsum = 42'(rem) * 42'(GWO_CDEG_RAD_Q40) + 42'd512;
  assign xs   = x >>> step;
  assign ys   = y >>> step;
  assign at   = $signed({4'b0000, GWO_ATAN[GWO_ATAN_IDX_W'(step)]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (start) begin
            quad <= quad_c;
            rem  <= rem_c[13:0];
            y    <= '0;
            step <= '0;
            if (rem_c == 16'd0) begin
              x     <= GWO_ONE_Q30;
              state <= C_FIX;
            end else begin
              x     <= GWO_GAIN_Q30;
              state <= C_ZMUL;
            end
          end
        end
        C_ZMUL: begin
          z     <= $signed({2'b00, zsum[41:10]});
          state <= C_ITER;
        end
        C_ITER: begin
          if (!z[33]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          if (step == IW'(CORDIC_STEPS - 1)) begin
            state <= C_FIX;
          end else begin
            step <= step + 1'b1;
          end
        end
        C_FIX: begin
          case (quad)
            2'd0: begin
              trig.sin_q <= y;
              trig.cos_q <= x;
            end
            2'd1: begin
              trig.sin_q <= x;
              trig.cos_q <= -y;
            end
            2'd2: begin
              trig.sin_q <= -y;
              trig.cos_q <= -x;
            end
            default: begin
              trig.sin_q <= -x;
              trig.cos_q <= y;
            end
          endcase
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/gwo_div.sv =====
// Radix-2 restoring divider, signed 64-bit by 34-bit, quotient truncated toward zero.
// Standalone; one quotient bit per cycle, no package dependencies.
module gwo_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [33:0] divisor,
  output logic               done,
  output logic signed [63:0] quot
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t     state;
  logic        neg;
  logic [63:0] num;
  logic [33:0] den;
  logic [33:0] rem;
  logic [34:0] trial;
  logic [5:0]  cnt;

  assign trial = {rem, num[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            neg   <= dividend[63] ^ divisor[33];
            num   <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            den   <= divisor[33] ? 34'(-divisor) : 34'(divisor);
            rem   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (trial >= {1'b0, den}) begin
            rem <= 34'(trial - {1'b0, den});
            num <= {num[62:0], 1'b1};
          end else begin
            rem <= trial[33:0];
            num <= {num[62:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd63) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          quot  <= neg ? -$signed(num) : $signed(num);
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/gyro_wheel_odometry_unit.sv =====
// Top level of the gyro wheel odometry unit: sequencer, shared multiplier and pose state.
// Depends on gwo_pkg, gwo_cordic, gwo_div and gyro_wheel_odometry_unit_defines.svh.
//
//   Channel  Direction  Handshake            Content
//   s_*      in         s_tvalid / s_tready  request item, kind in s_tuser
//   m_*      out        m_tvalid / m_tready  pose result, updated flag in m_tuser
//   cfg_*    in         cfg_valid / cfg_ready  register index and write data
//
// A load or unknown request goes straight to the result; a skipped or frozen sample ends
// after the travel terms. A straight-line sample takes one CORDIC pass. Off the
// straight-line case a second pass runs and each wheel in use adds two division terms,
// an unused wheel none. The input stays not ready from transfer until the result transfer
// completes; reset clears pose, primed bits and registers, with tracking set enabled.
`include "gyro_wheel_odometry_unit_defines.svh"
module gyro_wheel_odometry_unit
  import gwo_pkg::*;
#(
  parameter int CORDIC_STEPS = GWO_CORDIC_STEPS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // gyro_heading, gyro_valid, x_count_first, x_count_second, y_count_first,
  // y_count_second, count_valid, new_x, new_y, new_heading, zero fill
  input  logic [GWO_S_TDATA_W-1:0] s_tdata,
  // req_type
  input  logic [1:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // pose_x, pose_y, pose_heading
  output logic [GWO_M_TDATA_W-1:0] m_tdata,
  // updated
  output logic                     m_tuser,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [23:0]              cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_TRAV, ST_TSAT, ST_DECIDE, ST_THETA, ST_CWAIT,
    ST_ARC_MUL, ST_ARC_DIV, ST_ARC_WAIT, ST_LOW_ACC, ST_AVG, ST_ROT_WAIT,
    ST_ROT1, ST_ROT2, ST_ROT3, ST_ROT4, ST_ROT5, ST_OUT
  } state_t;

  state_t state;

  logic [GWO_S_TDATA_W-1:0] in_data;
  logic [1:0]               in_req;

  logic [23:0]        scale [2];
  logic [23:0]        offset [4];
  logic [1:0]         wheels;
  logic               enabled;

  logic [31:0]        est_x;
  logic [31:0]        est_y;
  logic [15:0]        est_heading;
  logic [15:0]        last_gyro;
  logic [31:0]        last_cnt [4];
  logic [3:0]         primed;

  logic [31:0]        delta [4];
  logic signed [31:0] trav [4];
  logic               skip;
  logic               use_gyro;
  logic [15:0]        gyro_red;
  logic signed [15:0] dh;
  logic signed [33:0] th;
  logic signed [33:0] sd;
  logic signed [33:0] cdv;
  logic signed [33:0] sh;
  logic signed [33:0] ch;
  logic signed [63:0] sum [2][2];
  logic signed [31:0] dxl;
  logic signed [31:0] dyl;
  logic signed [67:0] racc;
  logic [1:0]         k;
  logic               j;
  logic               updated;

  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] mul_p;

  logic [31:0]        cur [4];
  logic [3:0]         used;
  logic [3:0]         count_valid;
  logic [15:0]        gyro_in;
  logic [15:0]        new_heading;
  logic [15:0]        gyro_red_c;
  logic signed [16:0] dh_raw;
  logic signed [16:0] dh_adj;
  logic               use_gyro_c;
  logic               low;
  logic               go_arc;
  logic [15:0]        dh_fold;
  logic [15:0]        dh_abs;
  logic signed [17:0] head_sum;
  logic [15:0]        head_next;
  logic signed [33:0] coef;
  logic signed [67:0] th_full;
  logic signed [67:0] off_term;
  logic signed [63:0] avg [2][2];
  logic signed [67:0] rot_x;
  logic signed [67:0] rot_y;

  logic      cor_start;
  logic      cor_done;
  logic [15:0] cor_angle;
  gwo_trig_t trig;
  logic      div_start;
  logic      div_done;
  logic signed [63:0] quot;

  function automatic logic signed [63:0] half_trunc(input logic signed [63:0] v);
    return (v + $signed({63'd0, v[63]})) >>> 1;
  endfunction

  assign gyro_in     = in_data[15:0];
  assign cur[0]      = in_data[48:17];
  assign cur[1]      = in_data[80:49];
  assign cur[2]      = in_data[112:81];
  assign cur[3]      = in_data[144:113];
  assign count_valid = in_data[148:145];
  assign new_heading = in_data[228:213];

  assign used[0] = 1'b1;
  assign used[2] = 1'b1;
  assign used[1] = (GWO_WHEELS_PER_AXIS > 1) && wheels[0];
  assign used[3] = (GWO_WHEELS_PER_AXIS > 1) && wheels[1];

  always_comb begin
    gyro_red_c = (gyro_in >= GWO_FULL_TURN) ? gyro_in - GWO_FULL_TURN : gyro_in;
    dh_raw     = $signed({1'b0, gyro_red_c}) - $signed({1'b0, last_gyro});
    if (dh_raw > 17'sd18000) begin
      dh_adj = dh_raw - 17'sd36000;
    end else if (dh_raw <= -17'sd18000) begin
      dh_adj = dh_raw + 17'sd36000;
    end else begin
      dh_adj = dh_raw;
    end
    use_gyro_c = enabled && in_data[16];
  end

  assign low     = (dh > -GWO_LOW_TURN) && (dh < GWO_LOW_TURN);
  assign go_arc  = enabled && !skip && !low;
  assign dh_fold = dh[15] ? 16'($signed({dh[15], dh}) + 17'sd36000) : dh;
  assign dh_abs  = dh[15] ? 16'(-dh) : dh;

  assign head_sum  = $signed({2'b00, est_heading}) + $signed({{2{dh[15]}}, dh});
  assign head_next = head_sum[17] ? 16'(head_sum + 18'sd36000) :
                     (head_sum >= 18'sd36000) ? 16'(head_sum - 18'sd36000) :
                     head_sum[15:0];

  always_comb begin
    case ({k[1], j})
      2'b00:   coef = sd;
      2'b01:   coef = cdv - GWO_ONE_Q30;
      2'b10:   coef = GWO_ONE_Q30 - cdv;
      default: coef = sd;
    endcase
  end

  assign th_full  = (mul_p + 68'sd512) >>> 10;
  assign off_term = mul_p >>> 30;
  assign rot_x    = (racc + mul_p) >>> 30;
  assign rot_y    = (racc - mul_p) >>> 30;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        avg[a][b] = used[2 * a + 1] ? half_trunc(sum[a][b]) : sum[a][b];
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_TRAV: begin
        mul_a = $signed({10'd0, scale[k[1]]});
        mul_b = $signed({{2{delta[k][31]}}, delta[k]});
      end
      ST_DECIDE: begin
        mul_a = $signed({18'd0, dh_abs});
        mul_b = $signed({6'd0, GWO_CDEG_RAD_Q40});
      end
      ST_ARC_MUL: begin
        mul_a = coef;
        mul_b = $signed({{2{trav[k][31]}}, trav[k]});
      end
      ST_ARC_DIV, ST_ARC_WAIT: begin
        mul_a = coef;
        mul_b = $signed({{10{offset[k][23]}}, offset[k]});
      end
      ST_ROT1: begin
        mul_a = $signed({{2{dxl[31]}}, dxl});
        mul_b = ch;
      end
      ST_ROT2: begin
        mul_a = $signed({{2{dyl[31]}}, dyl});
        mul_b = sh;
      end
      ST_ROT3: begin
        mul_a = $signed({{2{dyl[31]}}, dyl});
        mul_b = ch;
      end
      ST_ROT4: begin
        mul_a = $signed({{2{dxl[31]}}, dxl});
        mul_b = sh;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  assign cor_start = (state == ST_DECIDE && go_arc) || state == ST_AVG;
  assign cor_angle = (state == ST_AVG) ? last_gyro : dh_fold;
  assign div_start = (state == ST_ARC_DIV);

  gwo_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .done  (cor_done),
    .trig  (trig)
  );

  gwo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p[63:0]),
    .divisor  (th),
    .done     (div_done),
    .quot     (quot)
  );

  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = (state == ST_OUT);
  assign m_tdata   = {est_heading, est_y, est_x};
  assign m_tuser   = updated;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      est_x       <= '0;
      est_y       <= '0;
      est_heading <= '0;
      last_gyro   <= '0;
      primed      <= '0;
      updated     <= 1'b0;
      k           <= '0;
      j           <= 1'b0;
      scale[0]    <= '0;
      scale[1]    <= '0;
      for (int w = 0; w < 4; w++) begin
        offset[w] <= '0;
      end
      wheels      <= '0;
      enabled     <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (gwo_cfg_idx_t'(cfg_index))
          CFG_X_TRAVEL:         scale[0]  <= cfg_data;
          CFG_Y_TRAVEL:         scale[1]  <= cfg_data;
          CFG_X_OFFSET_FIRST:   offset[0] <= cfg_data;
          CFG_X_OFFSET_SECOND:  offset[1] <= cfg_data;
          CFG_Y_OFFSET_FIRST:   offset[2] <= cfg_data;
          CFG_Y_OFFSET_SECOND:  offset[3] <= cfg_data;
          CFG_WHEELS_IN_USE:    wheels    <= cfg_data[1:0];
          CFG_TRACKING_ENABLED: enabled   <= cfg_data[0];
          default:              enabled   <= enabled;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            in_data <= s_tdata;
            in_req  <= s_tuser;
            state   <= ST_PREP;
          end
        end
        ST_PREP: begin
          updated <= 1'b0;
          case (in_req)
            REQ_SAMPLE: begin
              for (int w = 0; w < 4; w++) begin
                delta[w] <= cur[w] - last_cnt[w];
                if (!used[w]) begin
                  primed[w] <= 1'b0;
                end else if (count_valid[w]) begin
                  last_cnt[w] <= cur[w];
                  primed[w]   <= 1'b1;
                end else begin
                  primed[w] <= 1'b0;
                end
              end
              skip     <= |(used & ~(count_valid & primed));
              use_gyro <= use_gyro_c;
              gyro_red <= gyro_red_c;
              dh       <= use_gyro_c ? dh_adj[15:0] : 16'sd0;
              k        <= '0;
              state    <= ST_TRAV;
            end
            REQ_LOAD_HEADING: begin
              est_heading <= (new_heading >= GWO_FULL_TURN) ?
                             new_heading - GWO_FULL_TURN : new_heading;
              state       <= ST_OUT;
            end
            REQ_LOAD_POSITION: begin
              est_x <= in_data[180:149];
              est_y <= in_data[212:181];
              state <= ST_OUT;
            end
            default: state <= ST_OUT;
          endcase
        end
        ST_TRAV: state <= ST_TSAT;
        ST_TSAT: begin
          trav[k] <= gwo_sat32(mul_p);
          if (k == 2'd3) begin
            k     <= '0;
            state <= ST_DECIDE;
          end else begin
            k     <= k + 1'b1;
            state <= ST_TRAV;
          end
        end
        ST_DECIDE: begin
          for (int a = 0; a < 2; a++) begin
            sum[a][0] <= '0;
            sum[a][1] <= '0;
          end
          j <= 1'b0;
          if (!enabled || skip) begin
            state <= ST_OUT;
          end else if (low) begin
            state <= ST_LOW_ACC;
          end else begin
            state <= ST_THETA;
          end
        end
        ST_THETA: begin
          th    <= dh[15] ? -th_full[33:0] : th_full[33:0];
          state <= ST_CWAIT;
        end
        ST_CWAIT: begin
          if (cor_done) begin
            sd    <= trig.sin_q;
            cdv   <= trig.cos_q;
            state <= ST_ARC_MUL;
          end
        end
        ST_ARC_MUL: begin
          if (!used[k]) begin
            if (k == 2'd3) begin
              state <= ST_AVG;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            state <= ST_ARC_DIV;
          end
        end
        ST_ARC_DIV: state <= ST_ARC_WAIT;
        ST_ARC_WAIT: begin
          if (div_done) begin
            if (k[1]) begin
              sum[1][j] <= sum[1][j] + quot + off_term[63:0];
            end else begin
              sum[0][j] <= sum[0][j] + quot - off_term[63:0];
            end
            if (!j) begin
              j     <= 1'b1;
              state <= ST_ARC_MUL;
            end else begin
              j <= 1'b0;
              if (k == 2'd3) begin
                state <= ST_AVG;
              end else begin
                k     <= k + 1'b1;
                state <= ST_ARC_MUL;
              end
            end
          end
        end
        ST_LOW_ACC: begin
          if (used[k]) begin
            sum[k[1]][k[1]] <= sum[k[1]][k[1]] + 64'(trav[k]);
          end
          if (k == 2'd3) begin
            state <= ST_AVG;
          end else begin
            k <= k + 1'b1;
          end
        end
        ST_AVG: begin
          dxl   <= gwo_sat32(68'(avg[0][0] + avg[1][0]));
          dyl   <= gwo_sat32(68'(avg[0][1] + avg[1][1]));
          state <= ST_ROT_WAIT;
        end
        ST_ROT_WAIT: begin
          if (cor_done) begin
            sh    <= trig.sin_q;
            ch    <= trig.cos_q;
            state <= ST_ROT1;
          end
        end
        ST_ROT1: state <= ST_ROT2;
        ST_ROT2: begin
          racc  <= mul_p;
          state <= ST_ROT3;
        end
        ST_ROT3: begin
          est_x <= est_x + rot_x[31:0];
          state <= ST_ROT4;
        end
        ST_ROT4: begin
          racc  <= mul_p;
          state <= ST_ROT5;
        end
        ST_ROT5: begin
          est_y       <= est_y + rot_y[31:0];
          est_heading <= head_next;
          if (use_gyro) begin
            last_gyro <= gyro_red;
          end
          updated     <= 1'b1;
          state       <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GWO_ASSERT(a_heading_range, clk, rst, est_heading < GWO_FULL_TURN)
  `GWO_ASSERT(a_gyro_range, clk, rst, last_gyro < GWO_FULL_TURN)
  `GWO_ASSERT_NXT(a_accept_prep, clk, rst, s_tvalid && s_tready, state == ST_PREP)
  `GWO_ASSERT_IMP(a_upd_sample, clk, rst, m_tvalid && m_tuser, in_req == REQ_SAMPLE)

endmodule
